>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is held low
`define STE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds through reset
`define STE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/ste_pkg.sv
// ---------------------------------------------------------------------------
// ste_pkg
// Constants, register map and defaults of the spectral transient extractor.
// ---------------------------------------------------------------------------
package ste_pkg;

    // default sizes
    localparam int MAX_BINS_DEF = 1024;
    localparam int HIST_MAX_DEF = 16;
    localparam int WIN_MAX_DEF  = 16;
    localparam int MAG_BITS_DEF = 24;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BETA        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RET_TRANS   = 3'd7;

    // register widths
    localparam int NUM_BINS_W = 11;
    localparam int LEN_W      = 5;
    localparam int ALPHA_W    = 16;
    localparam int BETA_W     = 12;
    localparam int RUN_W      = 11;

    // register reset values
    localparam logic [NUM_BINS_W-1:0] NUM_BINS_RST = 11'd1024;
    localparam logic [NUM_BINS_W-1:0] LOW_CUT_RST  = 11'd0;
    localparam logic [LEN_W-1:0]      HIST_LEN_RST = 5'd4;
    localparam logic [LEN_W-1:0]      WIN_LEN_RST  = 5'd4;
    localparam logic [ALPHA_W-1:0]    ALPHA_RST    = 16'd8192;
    localparam logic [BETA_W-1:0]     BETA_RST     = 12'd3686;
    localparam logic [RUN_W-1:0]      MIN_RUN_RST  = 11'd3;

    // arithmetic constants
    localparam int FRAC_BITS   = 12;
    localparam int ONE_LEVEL   = 65536;
    localparam int FLOOR_LEVEL = 1;
    localparam int MIN_START   = 655360;
    localparam logic [RUN_W-1:0] RUN_SAT = 11'd2047;

    // divider quotient bits per cycle
    localparam int DIV_RADIX_BITS = 4;

endpackage

>>> src/ste_if.sv
// ---------------------------------------------------------------------------
// ste_in_if / ste_out_if
// Valid/ready channels carrying bin beats into and results out of the block.
// ---------------------------------------------------------------------------
interface ste_in_if #(parameter int MAG_BITS = ste_pkg::MAG_BITS_DEF);
    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] magnitude;
    logic                frame_start;

    modport source (output valid, magnitude, frame_start, input ready);
    modport sink   (input valid, magnitude, frame_start, output ready);
endinterface

interface ste_out_if #(parameter int MAG_BITS = ste_pkg::MAG_BITS_DEF);
    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] out_magnitude;
    logic                transient;
    logic                last_bin;

    modport source (output valid, out_magnitude, transient, last_bin, input ready);
    modport sink   (input valid, out_magnitude, transient, last_bin, output ready);
endinterface

>>> src/ste_ram.sv
// ---------------------------------------------------------------------------
// ste_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ste_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/spectral_transient_extractor_top.sv
// ---------------------------------------------------------------------------
// spectral_transient_extractor_top
// Min-of-average transient detector on a stream of spectral bin magnitudes.
// ---------------------------------------------------------------------------
// Usage:
//  i_in carries one bin magnitude (Q8.16) per beat; frame_start marks bin 0.
//  o_out gives one result beat per input beat: the transient (or residual)
//  part of the same bin one frame earlier, its transient flag and last_bin.
//  Registers are written on i_cfg_we/i_cfg_idx/i_cfg_data; the user is to
//  write them only while idle, which the block itself does not enforce.
//  Flow: one bin at a time. Each beat goes through a scan of the history
//  and average memories, then a radix-16 divider over the history sum, then
//  write-back, which loads the result into the output register. When a run
//  of at least min_run bins ends, a marking sweep over the transient-mark
//  memory marks every bin of that run before the next beat is taken.
//  Reset: a clearing pass writes every entry of all memories; i_in.ready
//  stays low meanwhile, configuration writes are taken as ever.
//  Stall: the output register holds a finished result while the next beat
//  is taken; processing waits at write-back until the register is free.
// ---------------------------------------------------------------------------
module spectral_transient_extractor_top #(
    parameter int MAX_BINS = ste_pkg::MAX_BINS_DEF,
    parameter int HIST_MAX = ste_pkg::HIST_MAX_DEF,
    parameter int WIN_MAX  = ste_pkg::WIN_MAX_DEF,
    parameter int MAG_BITS = ste_pkg::MAG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ste_in_if.sink                        i_in,
    ste_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [ste_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ste_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ste_pkg::*;

    localparam int BIN_BITS  = $clog2(MAX_BINS);
    localparam int NB_BITS   = $clog2(MAX_BINS + 1);
    localparam int HS_BITS   = (HIST_MAX > 1) ? $clog2(HIST_MAX) : 1;
    localparam int WS_BITS   = $clog2(WIN_MAX);
    localparam int HL_BITS   = $clog2(HIST_MAX + 1);
    localparam int WL_BITS   = $clog2(WIN_MAX + 1);
    localparam int SC_MAX    = (HIST_MAX > WIN_MAX) ? HIST_MAX : WIN_MAX;
    localparam int CNT_BITS  = $clog2(SC_MAX + 1);
    localparam int SUM_BITS  = MAG_BITS + $clog2(HIST_MAX);
    localparam int DIV_STEPS = (SUM_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_BITS  = DIV_STEPS * DIV_RADIX_BITS;
    localparam int DSC_BITS  = $clog2(DIV_STEPS + 1);
    localparam int REM_BITS  = HL_BITS + 1;
    localparam int HA_BITS   = HS_BITS + BIN_BITS;
    localparam int AA_BITS   = WS_BITS + BIN_BITS;
    localparam int CLR_BITS  = (HA_BITS > AA_BITS) ? HA_BITS : AA_BITS;
    localparam int MS_BITS   = $clog2(MIN_START + 1);
    localparam int MN_BITS   = (MAG_BITS > MS_BITS) ? MAG_BITS : MS_BITS;
    localparam int THR_BITS  = ALPHA_W + MN_BITS;
    localparam int SH_BITS   = MAG_BITS + FRAC_BITS;
    localparam int CMP_BITS  = (SH_BITS > THR_BITS) ? SH_BITS : THR_BITS;
    localparam int PROD_BITS = MAG_BITS + BETA_W;
    localparam int PB_W      = 3 * MAG_BITS;

    // state codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_MARK  = 3'd5;

    // configuration registers
    logic [NUM_BINS_W-1:0] r_num_bins, r_low_cut;
    logic [LEN_W-1:0]      r_hist_len, r_win_len;
    logic [ALPHA_W-1:0]    r_alpha;
    logic [BETA_W-1:0]     r_beta;
    logic [RUN_W-1:0]      r_min_run;
    logic                  r_ret;

    // control state
    logic [2:0]          r_state, n_state;
    logic [CLR_BITS-1:0] r_clr;
    logic [BIN_BITS-1:0] r_bctr;
    logic [HS_BITS-1:0]  r_hslot;
    logic [WS_BITS-1:0]  r_wslot;
    logic [RUN_W-1:0]    r_run;
    logic [CNT_BITS-1:0] r_cnt, r_dj;
    logic                r_dv;
    logic [DSC_BITS-1:0] r_dcnt;
    logic [BIN_BITS-1:0] r_mp;
    logic [RUN_W-1:0]    r_mcnt;
    logic                r_ovalid;

    // per-beat working registers
    logic [MAG_BITS-1:0] r_mag;
    logic [BIN_BITS-1:0] r_bin;
    logic [HS_BITS-1:0]  r_hs;
    logic [WS_BITS-1:0]  r_ws, r_pw;
    logic                r_last, r_cut;
    logic [SUM_BITS-1:0] r_sum;
    logic [MN_BITS-1:0]  r_mn;
    logic [MAG_BITS-1:0] r_prior_new;
    logic [DIV_BITS-1:0] r_dvd;
    logic [REM_BITS-1:0] r_rem;
    logic [THR_BITS-1:0] r_thr;
    logic [MAG_BITS-1:0] r_w;
    logic [MAG_BITS-1:0] r_omag;
    logic                r_otr, r_olast;

    // effective settings
    logic [NB_BITS-1:0] c_nb, c_lc;
    logic [HL_BITS-1:0] c_hl;
    logic [WL_BITS-1:0] c_wl;
    logic [CNT_BITS-1:0] c_scan_n;

    always_comb begin
        if (r_num_bins == '0) begin
            c_nb = NB_BITS'(1);
        end else if (32'(r_num_bins) > MAX_BINS) begin
            c_nb = NB_BITS'(MAX_BINS);
        end else begin
            c_nb = NB_BITS'(r_num_bins);
        end
        if (32'(r_low_cut) > 32'(c_nb)) begin
            c_lc = '0;
        end else begin
            c_lc = NB_BITS'(r_low_cut);
        end
        if (r_hist_len == '0) begin
            c_hl = HL_BITS'(1);
        end else if (32'(r_hist_len) > HIST_MAX) begin
            c_hl = HL_BITS'(HIST_MAX);
        end else begin
            c_hl = HL_BITS'(r_hist_len);
        end
        if (32'(r_win_len) < 2) begin
            c_wl = WL_BITS'(2);
        end else if (32'(r_win_len) > WIN_MAX) begin
            c_wl = WL_BITS'(WIN_MAX);
        end else begin
            c_wl = WL_BITS'(r_win_len);
        end
        c_scan_n = (32'(c_hl) > 32'(c_wl)) ? CNT_BITS'(c_hl) : CNT_BITS'(c_wl);
    end

    // bin and slot selection for an incoming beat
    logic                c_accept;
    logic [BIN_BITS-1:0] c_b;
    logic [HS_BITS-1:0]  c_hs;
    logic [WS_BITS-1:0]  c_ws, c_pw;
    logic                c_last, c_cut;

    assign c_accept = i_in.valid && i_in.ready;

    always_comb begin
        c_b = i_in.frame_start ? '0 : r_bctr;
        if (32'(c_b) >= 32'(c_nb)) begin
            c_b = '0;
        end
        c_hs   = (32'(r_hslot) < 32'(c_hl)) ? r_hslot : '0;
        c_ws   = (32'(r_wslot) < 32'(c_wl)) ? r_wslot : '0;
        c_pw   = (c_ws == '0) ? WS_BITS'(32'(c_wl) - 1) : c_ws - 1'b1;
        c_last = (32'(c_b) == 32'(c_nb) - 1);
        c_cut  = (32'(c_b) < 32'(c_lc));
    end

    // memories
    logic                we_hist, we_avg, we_pb, we_mk;
    logic [HA_BITS-1:0]  wa_hist, ra_hist;
    logic [AA_BITS-1:0]  wa_avg, ra_avg;
    logic [BIN_BITS-1:0] wa_pb, wa_mk;
    logic [MAG_BITS-1:0] wd_hist, wd_avg, rd_hist, rd_avg;
    logic [PB_W-1:0]     wd_pb, rd_pb;
    logic                wd_mk, rd_mk;

    ste_ram #(.WIDTH(MAG_BITS), .DEPTH(2 ** HA_BITS)) u_hist_ram (
        .i_clk(i_clk), .i_we(we_hist), .i_waddr(wa_hist), .i_wdata(wd_hist),
        .i_raddr(ra_hist), .o_rdata(rd_hist)
    );
    ste_ram #(.WIDTH(MAG_BITS), .DEPTH(2 ** AA_BITS)) u_avg_ram (
        .i_clk(i_clk), .i_we(we_avg), .i_waddr(wa_avg), .i_wdata(wd_avg),
        .i_raddr(ra_avg), .o_rdata(rd_avg)
    );
    ste_ram #(.WIDTH(PB_W), .DEPTH(2 ** BIN_BITS)) u_bin_ram (
        .i_clk(i_clk), .i_we(we_pb), .i_waddr(wa_pb), .i_wdata(wd_pb),
        .i_raddr(r_bin), .o_rdata(rd_pb)
    );
    ste_ram #(.WIDTH(1), .DEPTH(2 ** BIN_BITS)) u_mark_ram (
        .i_clk(i_clk), .i_we(we_mk), .i_waddr(wa_mk), .i_wdata(wd_mk),
        .i_raddr(r_bin), .o_rdata(rd_mk)
    );

    assign ra_hist = {r_cnt[HS_BITS-1:0], r_bin};
    assign ra_avg  = {r_cnt[WS_BITS-1:0], r_bin};

    // per-bin word: release level, delayed magnitude, prior average
    logic [MAG_BITS-1:0] pb_rel, pb_dm, pb_pa;
    assign pb_rel = rd_pb[3*MAG_BITS-1:2*MAG_BITS];
    assign pb_dm  = rd_pb[2*MAG_BITS-1:MAG_BITS];
    assign pb_pa  = rd_pb[MAG_BITS-1:0];

    // divider: four restoring steps a cycle, narrow remainder
    logic [REM_BITS-1:0] c_rem;
    logic [DIV_BITS-1:0] c_dvd;

    always_comb begin
        c_rem = r_rem;
        c_dvd = r_dvd;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            c_rem = {c_rem[REM_BITS-2:0], c_dvd[DIV_BITS-1]};
            c_dvd = {c_dvd[DIV_BITS-2:0], 1'b0};
            if (c_rem >= REM_BITS'(c_hl)) begin
                c_rem    = c_rem - REM_BITS'(c_hl);
                c_dvd[0] = 1'b1;
            end
        end
    end

    // products, registered during the divide
    logic [THR_BITS-1:0]  c_thr;
    logic [PROD_BITS-1:0] c_wprod;
    assign c_thr   = THR_BITS'(r_alpha) * THR_BITS'(r_mn);
    assign c_wprod = PROD_BITS'(pb_rel) * PROD_BITS'(r_beta);

    // write-back decisions
    logic                c_free, c_exceed, c_mk, c_sweep;
    logic [RUN_W-1:0]    c_run_inc;
    logic [MAG_BITS-1:0] c_res, c_part, c_rel_new, c_avg;
    logic [BIN_BITS-1:0] c_sw_first;
    logic [RUN_W-1:0]    c_sw_cnt;

    assign c_free = !r_ovalid || o_out.ready;
    assign c_avg  = r_dvd[MAG_BITS-1:0];

    always_comb begin
        c_exceed  = CMP_BITS'({r_mag, {FRAC_BITS{1'b0}}}) > CMP_BITS'(r_thr);
        c_run_inc = (r_run == RUN_SAT) ? r_run : r_run + 1'b1;
        c_mk      = rd_mk && !r_cut;
        // release and output part of the delayed bin
        if (rd_mk) begin
            c_res = (r_w < pb_pa) ? r_w : pb_pa;
        end else begin
            c_res = (r_w > MAG_BITS'(FLOOR_LEVEL)) ? r_w : MAG_BITS'(FLOOR_LEVEL);
        end
        if (r_cut) begin
            c_rel_new = pb_rel;
            c_part    = r_ret ? '0 : pb_dm;
        end else begin
            c_rel_new = c_res;
            c_part    = (c_res < pb_dm) ? c_res : pb_dm;
            if (r_ret) begin
                c_part = pb_dm - c_part;
            end
        end
        // span to mark when a run closes
        c_sweep    = 1'b0;
        c_sw_first = '0;
        c_sw_cnt   = '0;
        if (!r_cut) begin
            if (c_exceed) begin
                if (r_last && c_run_inc >= r_min_run
                        && 32'(c_run_inc) <= 32'(r_bin) + 1) begin
                    c_sweep    = 1'b1;
                    c_sw_first = BIN_BITS'(32'(r_bin) + 1 - 32'(c_run_inc));
                    c_sw_cnt   = c_run_inc;
                end
            end else if (r_run != '0 && r_run >= r_min_run
                    && 32'(r_run) <= 32'(r_bin)) begin
                c_sweep    = 1'b1;
                c_sw_first = BIN_BITS'(32'(r_bin) - 32'(r_run));
                c_sw_cnt   = r_run;
            end
        end
    end

    // memory write ports
    always_comb begin
        we_hist = 1'b0;
        we_avg  = 1'b0;
        we_pb   = 1'b0;
        we_mk   = 1'b0;
        wa_hist = {r_hs, r_bin};
        wa_avg  = {r_ws, r_bin};
        wa_pb   = r_bin;
        wa_mk   = r_bin;
        wd_hist = r_mag;
        wd_avg  = c_avg;
        wd_pb   = {c_rel_new, r_mag, r_cut ? pb_pa : r_prior_new};
        wd_mk   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                we_hist = 1'b1;
                we_avg  = 1'b1;
                we_pb   = 1'b1;
                we_mk   = 1'b1;
                wa_hist = r_clr[HA_BITS-1:0];
                wa_avg  = r_clr[AA_BITS-1:0];
                wa_pb   = r_clr[BIN_BITS-1:0];
                wa_mk   = r_clr[BIN_BITS-1:0];
                wd_hist = '0;
                wd_avg  = '0;
                wd_pb   = {MAG_BITS'(ONE_LEVEL), {(2 * MAG_BITS){1'b0}}};
            end
            ST_WRITE: begin
                we_hist = c_free && !r_cut;
                we_avg  = c_free && !r_cut;
                we_pb   = c_free;
                we_mk   = c_free;
            end
            ST_MARK: begin
                we_mk = 1'b1;
                wa_mk = r_mp;
                wd_mk = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == '1) n_state = ST_IDLE;
            ST_IDLE:  if (c_accept) n_state = ST_SCAN;
            ST_SCAN:  if (r_cnt == c_scan_n) n_state = ST_DIV;
            ST_DIV:   if (32'(r_dcnt) == DIV_STEPS) n_state = ST_WRITE;
            ST_WRITE: if (c_free) n_state = c_sweep ? ST_MARK : ST_IDLE;
            ST_MARK:  if (r_mcnt == RUN_W'(1)) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= NUM_BINS_RST;
            r_low_cut  <= LOW_CUT_RST;
            r_hist_len <= HIST_LEN_RST;
            r_win_len  <= WIN_LEN_RST;
            r_alpha    <= ALPHA_RST;
            r_beta     <= BETA_RST;
            r_min_run  <= MIN_RUN_RST;
            r_ret      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_BINS:    r_num_bins <= i_cfg_data[NUM_BINS_W-1:0];
                REG_LOW_CUT:     r_low_cut  <= i_cfg_data[NUM_BINS_W-1:0];
                REG_HISTORY_LEN: r_hist_len <= i_cfg_data[LEN_W-1:0];
                REG_WINDOW_LEN:  r_win_len  <= i_cfg_data[LEN_W-1:0];
                REG_ALPHA:       r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                REG_BETA:        r_beta     <= i_cfg_data[BETA_W-1:0];
                REG_MIN_RUN:     r_min_run  <= i_cfg_data[RUN_W-1:0];
                REG_RET_TRANS:   r_ret      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_bctr   <= '0;
            r_hslot  <= '0;
            r_wslot  <= '0;
            r_run    <= '0;
            r_cnt    <= '0;
            r_dj     <= '0;
            r_dv     <= 1'b0;
            r_dcnt   <= '0;
            r_mp     <= '0;
            r_mcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register: loaded at write-back, emptied when taken
            if (r_state == ST_WRITE && c_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    if (c_accept) begin
                        r_cnt <= '0;
                        r_dv  <= 1'b0;
                        if (c_b == '0) begin
                            r_run <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    r_dv <= (r_cnt < c_scan_n);
                    r_dj <= r_cnt;
                    if (r_cnt != c_scan_n) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_dcnt <= '0;
                end
                ST_DIV: r_dcnt <= r_dcnt + 1'b1;
                ST_WRITE: begin
                    if (c_free) begin
                        if (!r_cut) begin
                            r_run <= c_exceed ? c_run_inc : '0;
                        end
                        if (r_last) begin
                            r_hslot <= (32'(r_hs) + 1 == 32'(c_hl)) ? '0 : r_hs + 1'b1;
                            r_wslot <= (32'(r_ws) + 1 == 32'(c_wl)) ? '0 : r_ws + 1'b1;
                            r_bctr  <= '0;
                        end else begin
                            r_bctr <= r_bin + 1'b1;
                        end
                        r_mp   <= c_sw_first;
                        r_mcnt <= c_sw_cnt;
                    end
                end
                ST_MARK: begin
                    r_mp   <= r_mp + 1'b1;
                    r_mcnt <= r_mcnt - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (c_accept) begin
                    r_mag  <= i_in.magnitude;
                    r_bin  <= c_b;
                    r_hs   <= c_hs;
                    r_ws   <= c_ws;
                    r_pw   <= c_pw;
                    r_last <= c_last;
                    r_cut  <= c_cut;
                    r_sum  <= '0;
                    r_mn   <= MN_BITS'(MIN_START);
                end
            end
            ST_SCAN: begin
                // fold one history slot and one average slot per cycle
                if (r_dv) begin
                    if (32'(r_dj) < 32'(c_hl)) begin
                        if (32'(r_dj) == 32'(r_hs)) begin
                            r_sum <= r_sum + SUM_BITS'(r_mag);
                        end else begin
                            r_sum <= r_sum + SUM_BITS'(rd_hist);
                        end
                    end
                    if (32'(r_dj) < 32'(c_wl)) begin
                        if (32'(r_dj) != 32'(r_ws) && MN_BITS'(rd_avg) < r_mn) begin
                            r_mn <= MN_BITS'(rd_avg);
                        end
                        if (32'(r_dj) == 32'(r_pw)) begin
                            r_prior_new <= rd_avg;
                        end
                    end
                end
            end
            ST_DIV: begin
                r_thr <= c_thr;
                r_w   <= c_wprod[PROD_BITS-1:BETA_W];
                if (r_dcnt == '0) begin
                    r_dvd <= DIV_BITS'(r_sum);
                    r_rem <= '0;
                end else begin
                    r_dvd <= c_dvd;
                    r_rem <= c_rem;
                end
            end
            ST_WRITE: begin
                if (c_free) begin
                    r_omag  <= c_part;
                    r_otr   <= c_mk;
                    r_olast <= r_last;
                end
            end
            default: begin
            end
        endcase
    end

    // channel outputs
    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_ovalid;
    assign o_out.out_magnitude = r_omag;
    assign o_out.transient     = r_otr;
    assign o_out.last_bin      = r_olast;
endmodule

>>> src/ste_checker.sv
// ---------------------------------------------------------------------------
// ste_assertions
// Port-level checks of the transient extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ste_assertions (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);
    logic [1:0] r_pend;
    logic       c_in_beat, c_out_beat;

    assign c_in_beat  = i_in_valid && i_in_ready;
    assign c_out_beat = i_out_valid && i_out_ready;

    // beats taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (c_in_beat && !c_out_beat) begin
            r_pend <= r_pend + 1'b1;
        end else if (!c_in_beat && c_out_beat) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    `STE_ASSERT_ALWAYS(a_no_ready_after_rst, i_clk, !i_rst_n |=> !i_in_ready, "ready after reset")
    `STE_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped")
    `STE_ASSERT(a_no_extra_out, i_clk, i_rst_n, c_out_beat |-> r_pend != 2'd0, "result without input")
    `STE_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_ready |-> r_pend <= 2'd1, "ready while busy")
endmodule

bind spectral_transient_extractor_top ste_assertions u_ste_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
